/* hdl/vas_pkg.sv */
// shared types, constants and sizes of the variable activity scorer
package vas_pkg;

	localparam int NUM_VARS   = 1024;
	localparam int IDX_W      = $clog2(NUM_VARS);
	localparam int LOW_W      = $clog2(NUM_VARS + 1);
	localparam int FRAC_BITS  = 16;
	localparam int SCORE_W    = 48;
	localparam int CONF_W     = 32;
	localparam int MODE_W     = 2;
	localparam int OP_W       = 2;
	localparam int GAP_W      = 7;
	localparam int FACT_W     = 7;
	localparam int PROD_W     = SCORE_W + FACT_W;
	localparam int DIV_DIGITS = 8;
	localparam int DIV_W      = ((PROD_W + DIV_DIGITS - 1) / DIV_DIGITS) * DIV_DIGITS;
	localparam int DIV_STAGES = DIV_W / DIV_DIGITS;
	localparam int DIVISOR    = 100;
	localparam int REM_W      = $clog2(DIVISOR);
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 2;

	localparam logic [SCORE_W-1:0] SCORE_MAX   = '1;
	localparam logic [SCORE_W-1:0] SCORE_ONE   = SCORE_W'(1) << FRAC_BITS;
	localparam logic [CONF_W-1:0]  CONF_MAX    = '1;
	localparam logic [CONF_W-1:0]  HALVE_COUNT = CONF_W'(256);
	localparam logic [GAP_W-1:0]   GAP_LIMIT   = GAP_W'(101);
	localparam logic [FACT_W-1:0]  FACT_DECAY  = FACT_W'(99);
	localparam logic [FACT_W-1:0]  FACT_HALVE  = FACT_W'(50);

	typedef enum logic [OP_W-1:0] {
		OP_UPDATE = 2'd0,
		OP_TARGET = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DECAY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HALVE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_AVG   = 2'd3;

	typedef enum logic [1:0] {
		K_READ  = 2'd0,
		K_BUMP  = 2'd1,
		K_AVG   = 2'd2,
		K_SCALE = 2'd3
	} kind_t;

	typedef struct packed {
		logic              walk;
		logic [FACT_W-1:0] walk_factor;
		logic [IDX_W-1:0]  walk_start;
		kind_t             kind;
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [FACT_W-1:0] factor;
		logic [CONF_W-1:0] conflicts;
	} cmd_t;

	typedef struct packed {
		logic             item;
		logic [IDX_W-1:0] addr;
	} div_tag_t;

endpackage

/* hdl/vas_front.sv */
// front end: mode register, conflict counter, lowest index and command classification
module vas_front import vas_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [OP_W-1:0]    op,
	input  logic [IDX_W-1:0]   var_index,
	input  logic               first_of_cube,
	input  logic [GAP_W-1:0]   gap,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [MODE_W-1:0]  branching_mode,
	input  logic               cmdq_full,
	input  logic               clearing,
	output logic               enq,
	output cmd_t               cmd
);

	logic [MODE_W-1:0] mode_q;
	logic [CONF_W-1:0] conf_q;
	logic [LOW_W-1:0]  lowest_q;

	logic              is_upd;
	logic              is_tgt;
	logic              counts;
	logic              idx_ok;
	logic              halve_hit;
	logic [CONF_W-1:0] cnt_inc;
	logic [CONF_W-1:0] conf_next;
	logic              lower;

	assign cfg_ready = 1'b1;
	assign full      = cmdq_full | clearing;
	assign enq       = push & ~full;

	assign is_upd = (op == OP_UPDATE);
	assign is_tgt = (op == OP_TARGET);
	assign counts = first_of_cube & (is_upd | is_tgt);
	assign idx_ok = {1'b0, var_index} < LOW_W'(NUM_VARS);
	assign lower  = idx_ok & ({1'b0, var_index} < lowest_q);

	always_comb begin
		cnt_inc = conf_q;
		if (counts && conf_q != CONF_MAX) begin
			cnt_inc = conf_q + CONF_W'(1);
		end
		halve_hit = is_upd & first_of_cube & (mode_q == MODE_HALVE) & (cnt_inc == HALVE_COUNT);
		conf_next = halve_hit ? '0 : cnt_inc;
	end

	always_comb begin
		cmd.walk        = is_upd & first_of_cube & ((mode_q == MODE_DECAY) | halve_hit)
		                  & (lowest_q < LOW_W'(NUM_VARS));
		cmd.walk_factor = halve_hit ? FACT_HALVE : FACT_DECAY;
		cmd.walk_start  = lowest_q[IDX_W-1:0];
		cmd.valid       = idx_ok;
		cmd.idx         = var_index;
		cmd.factor      = (gap >= GAP_LIMIT) ? '0 : FACT_W'(GAP_LIMIT - gap);
		cmd.conflicts   = conf_next;
		cmd.kind        = K_READ;
		if (is_upd) begin
			unique case (mode_q)
				MODE_DECAY, MODE_HALVE: cmd.kind = K_BUMP;
				MODE_AVG:               cmd.kind = K_AVG;
				default:                cmd.kind = K_READ;
			endcase
		end else if (is_tgt) begin
			cmd.kind = K_SCALE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DECAY;
			conf_q   <= CONF_W'(1);
			lowest_q <= LOW_W'(NUM_VARS);
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= branching_mode;
			end
			if (enq) begin
				conf_q <= conf_next;
				if (counts && lower) begin
					lowest_q <= {1'b0, var_index};
				end
			end
		end
	end

endmodule

/* hdl/vas_cmdq.sv */
// short command queue between the front end and the score engine
module vas_cmdq import vas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic enq,
	input  cmd_t enq_cmd,
	output logic full,
	input  logic deq,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             entry_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[wptr_q] <= enq_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (enq) begin
				wptr_q <= (wptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (deq) begin
				rptr_q <= (rptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hdl/vas_div100.sv */
// pipelined divide by one hundred, eight quotient bits per stage
module vas_div100 import vas_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [DIV_W-1:0]   in_dividend,
	input  div_tag_t           in_tag,
	output logic               out_vld,
	output logic [DIV_W-1:0]   out_quot,
	output div_tag_t           out_tag,
	output logic               busy
);

	logic [DIV_W-1:0] w_q   [DIV_STAGES];
	logic [REM_W-1:0] r_q   [DIV_STAGES];
	div_tag_t         tag_q [DIV_STAGES];
	logic             vld_q [DIV_STAGES];

	logic [DIV_W-1:0] src_w [DIV_STAGES];
	logic [REM_W-1:0] src_r [DIV_STAGES];
	logic [DIV_W-1:0] nxt_w [DIV_STAGES];
	logic [REM_W-1:0] nxt_r [DIV_STAGES];

	// restoring division: the remainder stays below the divisor, so each digit is narrow
	function automatic logic [DIV_W+REM_W-1:0] div_digits(input logic [DIV_W-1:0] w,
	                                                      input logic [REM_W-1:0] r);
		logic [DIV_W-1:0] wn;
		logic [REM_W-1:0] rn;
		logic [REM_W:0]   t;
		wn = w;
		rn = r;
		for (int i = 0; i < DIV_DIGITS; i++) begin
			t  = {rn, wn[DIV_W-1]};
			wn = {wn[DIV_W-2:0], 1'b0};
			if (t >= (REM_W + 1)'(DIVISOR)) begin
				t     = t - (REM_W + 1)'(DIVISOR);
				wn[0] = 1'b1;
			end
			rn = t[REM_W-1:0];
		end
		return {wn, rn};
	endfunction

	always_comb begin
		src_w[0] = in_dividend;
		src_r[0] = '0;
		for (int k = 1; k < DIV_STAGES; k++) begin
			src_w[k] = w_q[k-1];
			src_r[k] = r_q[k-1];
		end
		for (int k = 0; k < DIV_STAGES; k++) begin
			{nxt_w[k], nxt_r[k]} = div_digits(src_w[k], src_r[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			w_q[k] <= nxt_w[k];
			r_q[k] <= nxt_r[k];
		end
		tag_q[0] <= in_tag;
		for (int k = 1; k < DIV_STAGES; k++) begin
			tag_q[k] <= tag_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			vld_q[0] <= in_vld;
			for (int k = 1; k < DIV_STAGES; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_comb begin
		busy = 1'b0;
		for (int k = 0; k < DIV_STAGES; k++) begin
			busy = busy | vld_q[k];
		end
	end

	assign out_vld  = vld_q[DIV_STAGES-1];
	assign out_quot = w_q[DIV_STAGES-1];
	assign out_tag  = tag_q[DIV_STAGES-1];

endmodule

/* hdl/vas_back.sv */
// score engine: score memory, clearing pass, decay walk, item execution and result queue
module vas_back import vas_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_pop,
	output logic               clearing,
	output logic               empty,
	input  logic               pop,
	output logic [SCORE_W-1:0] score,
	output logic [CONF_W-1:0]  conflict_count
);

	localparam int RPTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
	localparam int RCNT_W = $clog2(RESQ_DEPTH + 1);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_WALK  = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_READ  = 7'b0010000,
		ST_EXEC  = 7'b0100000,
		ST_SCALE = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [SCORE_W-1:0] mem_q [NUM_VARS];
	logic [SCORE_W-1:0] rdata_q;
	logic [IDX_W-1:0]   raddr;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [SCORE_W-1:0] wdata;

	logic [IDX_W-1:0]   clr_addr_q;
	logic [IDX_W-1:0]   walk_addr_q;

	logic               rd_vld_s1;
	div_tag_t           rd_tag_s1;
	logic [FACT_W-1:0]  factor_s1;
	logic               vld_s2;
	div_tag_t           tag_s2;
	logic [PROD_W-1:0]  prod_s2;

	logic               issue;
	logic               div_out_vld;
	logic [DIV_W-1:0]   div_quot;
	div_tag_t           div_out_tag;
	logic               div_busy;
	logic [SCORE_W-1:0] scaled;

	logic [SCORE_W:0]   bump_sum;
	logic [SCORE_W:0]   avg_sum;
	logic [SCORE_W-1:0] exec_val;
	logic               done;
	logic [SCORE_W-1:0] result;
	logic               pipe_empty;

	logic [SCORE_W-1:0] res_score_q [RESQ_DEPTH];
	logic [CONF_W-1:0]  res_conf_q  [RESQ_DEPTH];
	logic [RPTR_W-1:0]  res_wptr_q;
	logic [RPTR_W-1:0]  res_rptr_q;
	logic [RCNT_W-1:0]  res_cnt_q;
	logic               res_pop;

	assign clearing = (state_q == ST_CLEAR);

	// read issue: walk entries always, the item only when it goes through the scaler
	assign issue = (state_q == ST_WALK) ||
	               ((state_q == ST_READ) && (cmd.kind == K_SCALE) && cmd.valid);
	assign raddr = (state_q == ST_WALK) ? walk_addr_q : cmd.idx;

	vas_div100 u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (vld_s2),
		.in_dividend (DIV_W'(prod_s2)),
		.in_tag      (tag_s2),
		.out_vld     (div_out_vld),
		.out_quot    (div_quot),
		.out_tag     (div_out_tag),
		.busy        (div_busy)
	);

	assign scaled     = (div_quot[DIV_W-1:SCORE_W] != '0) ? SCORE_MAX : div_quot[SCORE_W-1:0];
	assign pipe_empty = ~rd_vld_s1 & ~vld_s2 & ~div_busy;

	assign bump_sum = {1'b0, rdata_q} + {1'b0, SCORE_ONE};
	assign avg_sum  = {1'b0, rdata_q} + {1'b0, cmd.conflicts, FRAC_BITS'(0)};

	always_comb begin
		unique case (cmd.kind)
			K_BUMP:  exec_val = bump_sum[SCORE_W] ? SCORE_MAX : bump_sum[SCORE_W-1:0];
			K_AVG:   exec_val = avg_sum[SCORE_W:1];
			default: exec_val = rdata_q;
		endcase
	end

	always_comb begin
		done   = 1'b0;
		result = '0;
		if (state_q == ST_EXEC && !(cmd.kind == K_SCALE && cmd.valid)) begin
			done   = 1'b1;
			result = cmd.valid ? exec_val : '0;
		end else if (state_q == ST_SCALE && div_out_vld && div_out_tag.item) begin
			done   = 1'b1;
			result = scaled;
		end
	end

	assign cmd_pop = done;

	always_comb begin
		we    = 1'b0;
		waddr = cmd.idx;
		wdata = exec_val;
		priority if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else if (div_out_vld) begin
			we    = 1'b1;
			waddr = div_out_tag.addr;
			wdata = scaled;
		end else if (state_q == ST_EXEC && cmd.valid &&
		             (cmd.kind == K_BUMP || cmd.kind == K_AVG)) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == IDX_W'(NUM_VARS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid && res_cnt_q != RCNT_W'(RESQ_DEPTH)) begin
					state_d = cmd.walk ? ST_WALK : ST_READ;
				end
			end
			ST_WALK: begin
				if (walk_addr_q == IDX_W'(NUM_VARS - 1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (pipe_empty) state_d = ST_READ;
			end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: state_d = done ? ST_IDLE : ST_SCALE;
			ST_SCALE: begin
				if (done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			walk_addr_q <= '0;
			rd_vld_s1   <= 1'b0;
			vld_s2      <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			vld_s2    <= rd_vld_s1;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			end
			if (state_q == ST_IDLE) begin
				walk_addr_q <= cmd.walk_start;
			end else if (state_q == ST_WALK) begin
				walk_addr_q <= walk_addr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_tag_s1.item <= (state_q != ST_WALK);
		rd_tag_s1.addr <= raddr;
		factor_s1      <= (state_q == ST_WALK) ? cmd.walk_factor : cmd.factor;
		tag_s2         <= rd_tag_s1;
		prod_s2        <= PROD_W'(rdata_q) * PROD_W'(factor_s1);
	end

	// result queue, its head drives the output ports
	assign empty          = (res_cnt_q == '0);
	assign res_pop        = pop & ~empty;
	assign score          = res_score_q[res_rptr_q];
	assign conflict_count = res_conf_q[res_rptr_q];

	always_ff @(posedge clk) begin
		if (done) begin
			res_score_q[res_wptr_q] <= result;
			res_conf_q[res_wptr_q]  <= cmd.conflicts;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wptr_q <= '0;
			res_rptr_q <= '0;
			res_cnt_q  <= '0;
		end else begin
			if (done) begin
				res_wptr_q <= (res_wptr_q == RPTR_W'(RESQ_DEPTH - 1)) ? '0 : res_wptr_q + RPTR_W'(1);
			end
			if (res_pop) begin
				res_rptr_q <= (res_rptr_q == RPTR_W'(RESQ_DEPTH - 1)) ? '0 : res_rptr_q + RPTR_W'(1);
			end
			if (done && !res_pop) begin
				res_cnt_q <= res_cnt_q + RCNT_W'(1);
			end else if (res_pop && !done) begin
				res_cnt_q <= res_cnt_q - RCNT_W'(1);
			end
		end
	end

endmodule

/* hdl/variable_activity_scorer_unit.sv */
// Top level of the variable activity scorer.
// An item with no decay walk is taken from the command queue head, read, executed and written
// back to the result queue; a targeted decay also goes through the multiplier and divider.
// A decay or halve walk first rescales entries lowest_seen to NUM_VARS - 1, then drains the scaler.
// The engine handles one item at a time: the next leaves the command queue only when the last is done.
// After reset the score memory is cleared, one entry a cycle over all 1024 entries, while full is high.
module variable_activity_scorer_unit import vas_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [OP_W-1:0]    op,
	input  logic [IDX_W-1:0]   var_index,
	input  logic               first_of_cube,
	input  logic [GAP_W-1:0]   gap,
	output logic               empty,
	input  logic               pop,
	output logic [SCORE_W-1:0] score,
	output logic [CONF_W-1:0]  conflict_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [MODE_W-1:0]  branching_mode
);

	logic cmdq_full;
	logic clearing;
	logic enq;
	cmd_t enq_cmd;
	logic head_valid;
	cmd_t head_cmd;
	logic deq;

	vas_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.op             (op),
		.var_index      (var_index),
		.first_of_cube  (first_of_cube),
		.gap            (gap),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.branching_mode (branching_mode),
		.cmdq_full      (cmdq_full),
		.clearing       (clearing),
		.enq            (enq),
		.cmd            (enq_cmd)
	);

	vas_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.enq        (enq),
		.enq_cmd    (enq_cmd),
		.full       (cmdq_full),
		.deq        (deq),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	vas_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (head_valid),
		.cmd            (head_cmd),
		.cmd_pop        (deq),
		.clearing       (clearing),
		.empty          (empty),
		.pop            (pop),
		.score          (score),
		.conflict_count (conflict_count)
	);

endmodule
